### hdl/olist_pkg.sv
// shared constants, types and helpers for the ordered list core
// no dependencies; imported by every module in hdl/
package olist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PRE_STAGES = $clog2(CAPACITY);

  // item field widths
  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 4;
  localparam int LENGTH_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctrl_t;

  // sign-extend or truncate the item value to the stored width
  function automatic logic [DATA_WIDTH-1:0] to_key(input logic signed [VALUE_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

endpackage

### hdl/olist_cell.sv
// one list slot: holds an entry, compares it and shifts toward either neighbor
// depends on olist_pkg
module olist_cell (
  input  logic                         clk,
  input  olist_pkg::cell_ctrl_t        ctrl,
  input  logic                         occupied,
  input  logic [olist_pkg::DATA_WIDTH-1:0] cmp_key,
  input  logic [olist_pkg::DATA_WIDTH-1:0] left_data,
  input  logic [olist_pkg::DATA_WIDTH-1:0] right_data,
  output logic [olist_pkg::DATA_WIDTH-1:0] data,
  output logic                         match
);
  import olist_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= occupied && (data == cmp_key);
    end
    case (ctrl.op)
      CELL_TAKE_LEFT:  data <= left_data;
      CELL_TAKE_RIGHT: data <= right_data;
      default:         data <= data;
    endcase
  end

endmodule

### hdl/olist_find.sv
// first-match resolver: parallel prefix or over the cell match bits,
// plus index encoding of the first match; depends on olist_pkg
module olist_find (
  input  logic [olist_pkg::CAPACITY-1:0] match,
  output logic [olist_pkg::CAPACITY-1:0] at_or_after,
  output logic                           hit,
  output logic [olist_pkg::IDX_W-1:0]    index
);
  import olist_pkg::*;

  logic [CAPACITY-1:0] pre [PRE_STAGES+1];
  logic [CAPACITY-1:0] first;

  assign pre[0] = match;

  for (genvar s = 0; s < PRE_STAGES; s++) begin : g_stage
    for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
      if (i >= (1 << s)) begin : g_or
        assign pre[s+1][i] = pre[s][i] | pre[s][i-(1<<s)];
      end else begin : g_pass
        assign pre[s+1][i] = pre[s][i];
      end
    end
  end

  assign at_or_after = pre[PRE_STAGES];
  assign hit         = at_or_after[CAPACITY-1];
  assign first       = at_or_after & ~(at_or_after << 1);

  always_comb begin
    index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

endmodule

### hdl/ordered_list_insert_search_remove_core.sv
// top level of the ordered list core: a chain of list cells, the first-match
// resolver and the request/result handshake; depends on olist_pkg,
// olist_cell and olist_find
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   request | in_valid, in_stall, mode, value    | in
//   result  | out_valid, out_stall, hit,         | out
//           | position, length, rejected         |
//
// each item: the accept edge compares the value in every cell; the commit edge,
// once the result register is free, resolves the first match and shifts the cells
// a new item is taken only after the previous one has updated the cells
// rst (synchronous, active high) empties the list, drops out_valid and
// stalls the request channel
// a stalled result sits in the output register; the pending item waits for it
module ordered_list_insert_search_remove_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [olist_pkg::MODE_W-1:0]         mode,
  input  logic signed [olist_pkg::VALUE_W-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic [olist_pkg::POSITION_W-1:0]     position,
  output logic [olist_pkg::LENGTH_W-1:0]       length,
  output logic                                 rejected
);
  import olist_pkg::*;

  // control
  logic                  busy;
  logic                  accept;
  logic                  commit;
  mode_t                 mode_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [DATA_WIDTH-1:0] cmp_key;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  full;

  // cell chain
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  cell_ctrl_t            cell_ctrl [CAPACITY];

  // first-match
  logic [CAPACITY-1:0]   at_or_after;
  logic                  found;
  logic [IDX_W-1:0]      found_idx;

  logic                  do_insert;
  logic                  do_remove;

  assign accept   = in_valid && !in_stall;
  // no item is taken while in reset
  assign in_stall = busy || rst;
  // result register free, or being emptied this cycle
  assign commit   = busy && (!out_valid || !out_stall);
  assign cmp_key  = to_key(value);
  assign full     = (count == CNT_W'(CAPACITY));

  assign do_insert = (mode_q == MODE_INSERT) && !full;
  assign do_remove = (mode_q == MODE_REMOVE) && found;

  olist_find u_find (
    .match       (cell_match),
    .at_or_after (at_or_after),
    .hit         (found),
    .index       (found_idx)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    // head takes the new value on insert; tail refills with itself on remove
    if (i == 0) begin : g_head
      assign left_d = key_q;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end

    always_comb begin
      cell_ctrl[i].cmp_en = accept;
      cell_ctrl[i].op     = CELL_HOLD;
      if (commit && do_insert) begin
        cell_ctrl[i].op = CELL_TAKE_LEFT;
      end else if (commit && do_remove && at_or_after[i]) begin
        // every cell from the first match on closes the gap
        cell_ctrl[i].op = CELL_TAKE_RIGHT;
      end
    end

    olist_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .occupied   (CNT_W'(i) < count),
      .cmp_key    (cmp_key),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  always_comb begin
    case (mode_q)
      MODE_INSERT: count_next = do_insert ? count + CNT_W'(1) : count;
      MODE_REMOVE: count_next = do_remove ? count - CNT_W'(1) : count;
      MODE_CLEAR:  count_next = '0;
      default:     count_next = count;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (commit) begin
      busy <= 1'b0;
    end
    if (accept) begin
      mode_q <= mode_t'(mode);
      key_q  <= cmp_key;
    end
  end

  // list length
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (commit) begin
      hit      <= 1'b0;
      position <= '0;
      if ((mode_q == MODE_SEARCH || mode_q == MODE_REMOVE) && found) begin
        hit      <= 1'b1;
        position <= POSITION_W'(found_idx);
      end
      length   <= LENGTH_W'(count_next);
      rejected <= (mode_q == MODE_INSERT) && full;
    end
  end

endmodule

### sim/tb_top.sv
// self-checking testbench for ordered_list_insert_search_remove_core
// depends on olist_pkg and the core rtl; predicts every result from its own
// copy of the list and checks each result item against the oldest expectation
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  // run bounds
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 40;

  // receiver stall styles
  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  // one result item as the core reports it
  typedef struct packed {
    logic                  hit;
    logic [POSITION_W-1:0] position;
    logic [LENGTH_W-1:0]   length;
    logic                  rejected;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  mode_t                     in_mode = MODE_INSERT;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      hit;
  logic [POSITION_W-1:0]     position;
  logic [LENGTH_W-1:0]       length;
  logic                      rejected;

  // shadow copy of the list, index 0 is the head (newest entry)
  logic [DATA_WIDTH-1:0] shadow_list[$];
  // results still owed by the core, oldest first
  list_result_t          pending_results[$];
  // small set of values reused so that searches and removes find matches
  logic [VALUE_W-1:0]    value_pool[8];

  int fail_count  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  bit sender_gaps = 1'b1;
  int stall_style = STALL_NONE;
  int stall_phase = 0;
  int hold_left   = 0;

  ordered_list_insert_search_remove_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (in_mode),
    .value     (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .position  (position),
    .length    (length),
    .rejected  (rejected)
  );

  always #5ns clk = ~clk;

  // hard stop in case the core hangs or drops a result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: a long hold-off wins over the current stall style
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      case (stall_style)
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 35);
        STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // apply one operation to the shadow list and return the result it owes
  function automatic list_result_t apply_list_op(mode_t op, logic [VALUE_W-1:0] v);
    list_result_t          r;
    int                    found;
    logic [DATA_WIDTH-1:0] key;
    r     = '0;
    found = -1;
    key   = to_key(v);
    // first match counted from the head
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (found < 0 && shadow_list[i] == key) found = i;
    end
    case (op)
      MODE_INSERT: begin
        // a full list refuses the insert and stays as it was
        if (shadow_list.size() >= CAPACITY) r.rejected = 1'b1;
        else shadow_list.push_front(key);
      end
      MODE_SEARCH: begin
        if (found >= 0) begin
          r.hit      = 1'b1;
          r.position = POSITION_W'(found);
        end
      end
      MODE_REMOVE: begin
        if (found >= 0) begin
          r.hit      = 1'b1;
          r.position = POSITION_W'(found);
          shadow_list.delete(found);
        end
      end
      default: shadow_list.delete();
    endcase
    r.length = LENGTH_W'(shadow_list.size());
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result checker, samples at the rising edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display({"%0t: result item with none expected, expected nothing, ",
                    "actual hit=%0d pos=%0d len=%0d rej=%0d"},
                   $time, hit, position, length, rejected);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, hit);
        check_field("position", want.position, position);
        check_field("length", want.length, length);
        check_field("rejected", want.rejected, rejected);
      end
    end
  end

  // offer one item, with a random gap at the start of each burst;
  // valid stays high from one item to the next inside a burst
  task automatic send_item(mode_t op, logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (sender_gaps && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode  <= op;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    // accepted at this edge
    pending_results.push_back(apply_list_op(op, v));
    burst_left--;
  endtask

  // sender goes quiet until every owed result has come back
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic refill_pool();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
  endtask

  // mostly values that are stored or from the pool, now and then a fresh one
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && shadow_list.size() > 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (sel < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic mode_t pick_mode();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) return MODE_INSERT;
    if (w < 65) return MODE_SEARCH;
    if (w < 95) return MODE_REMOVE;
    return MODE_CLEAR;
  endfunction

  // empty list, filling to capacity, refusal when full, first match among
  // duplicates, the tail position, misses, clear
  task automatic test_directed();
    logic [VALUE_W-1:0] fill[16] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
      32'd5,         32'h1234_5678, 32'd5,         32'hdead_beef,
      32'd1,         32'hffff_fffe, 32'h5555_5555, 32'haaaa_aaaa,
      32'd100,       -32'sd100,     32'h0001_0000, 32'h4000_0000
    };
    sender_gaps = 1'b1;
    stall_style = STALL_RANDOM;
    // search and remove on an empty list miss
    send_item(MODE_SEARCH, 32'h0);
    send_item(MODE_REMOVE, 32'h7fff_ffff);
    foreach (fill[i]) send_item(MODE_INSERT, fill[i]);
    // full list refuses the insert
    send_item(MODE_INSERT, 32'd42);
    // oldest entry sits at the tail
    send_item(MODE_SEARCH, 32'h8000_0000);
    // duplicate: the newer copy is nearer the head
    send_item(MODE_SEARCH, 32'd5);
    send_item(MODE_SEARCH, 32'd42);
    send_item(MODE_REMOVE, 32'd5);
    send_item(MODE_SEARCH, 32'd5);
    send_item(MODE_REMOVE, 32'h8000_0000);
    send_item(MODE_REMOVE, 32'd42);
    send_item(MODE_CLEAR, 32'hffff_ffff);
    pause_until_drained();
  endtask

  // random mix of all operations, with stretches of each idling style
  task automatic test_random_mix();
    refill_pool();
    for (int n = 0; n < 210; n++) begin
      if (n == 0) begin
        stall_style = STALL_RANDOM;
        sender_gaps = 1'b1;
      end else if (n == 80) begin
        // a stretch with no idling on either side
        stall_style = STALL_NONE;
        sender_gaps = 1'b0;
      end else if (n == 130) begin
        stall_style = STALL_PERIODIC;
        sender_gaps = 1'b1;
      end
      send_item(pick_mode(), pick_value());
    end
    pause_until_drained();
  endtask

  // well-formed rounds: clear, fill to or past capacity, search, remove until empty
  task automatic test_fill_drain();
    int styles[4] = '{STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_RANDOM};
    int n_ins;
    logic [VALUE_W-1:0] v;
    for (int round = 0; round < 4; round++) begin
      refill_pool();
      stall_style = styles[round];
      sender_gaps = (round != 0);
      send_item(MODE_CLEAR, $urandom());
      n_ins = CAPACITY + $urandom_range(0, 3);
      repeat (n_ins) begin
        v = ($urandom_range(0, 1) != 0) ? value_pool[$urandom_range(0, 7)] : $urandom();
        send_item(MODE_INSERT, v);
      end
      repeat (3) send_item(MODE_SEARCH, pick_value());
      while (shadow_list.size() > 0) begin
        if ($urandom_range(0, 4) != 0) v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        else v = $urandom();
        send_item(MODE_REMOVE, v);
      end
      // remove on the emptied list misses
      send_item(MODE_REMOVE, pick_value());
    end
    pause_until_drained();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the core fills and stalls its input; then a full drain and a run with random stalls
  task automatic test_backpressure();
    refill_pool();
    stall_style = STALL_NONE;
    sender_gaps = 1'b0;
    hold_left   = 60;
    burst_left  = 40;
    repeat (25) send_item(pick_mode(), pick_value());
    pause_until_drained();
    stall_style = STALL_RANDOM;
    sender_gaps = 1'b1;
    repeat (10) send_item(pick_mode(), pick_value());
    pause_until_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix();
    test_fill_drain();
    test_backpressure();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### ordered_list_insert_search_remove_core.f
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/olist_find.sv
hdl/ordered_list_insert_search_remove_core.sv
sim/tb_top.sv
